### src/mstt_pkg.sv
package mstt_pkg;

   // size of the slot table
   localparam int NUM_SLOTS = 4;
   localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

   // field widths
   localparam int CMD_W     = 2;
   localparam int INDEX_W   = 2;
   localparam int TICK_W    = 32;
   localparam int MODE_W    = 2;
   localparam int MASK_W    = 4;

   // span that holds one bit per slot and covers the reported mask
   localparam int MASK_SPAN = (NUM_SLOTS > MASK_W) ? NUM_SLOTS : MASK_W;

   // command codes
   localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_START = 2'd1;
   localparam logic [CMD_W-1:0] CMD_STOP  = 2'd2;
   localparam logic [CMD_W-1:0] CMD_POLL  = 2'd3;

   // slot modes
   localparam logic [MODE_W-1:0] MODE_ONE_SHOT = 2'd1;
   localparam logic [MODE_W-1:0] MODE_PERIODIC = 2'd2;

   typedef struct packed {
      logic [CMD_W-1:0]   cmd;
      logic [INDEX_W-1:0] slot_index;
      logic [TICK_W-1:0]  timeout_ticks;
      logic [MODE_W-1:0]  timer_mode;
   } req_type;

   typedef struct packed {
      logic [MASK_W-1:0] expired_mask;
      logic [TICK_W-1:0] tick_now;
   } rsp_type;

   // one command issued to the slot bank
   typedef struct packed {
      logic    valid;
      req_type item;
   } op_type;

endpackage

### src/mstt_slot_bank.sv
module mstt_slot_bank import mstt_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  op_type  op,
   output rsp_type result
);

   logic [TICK_W-1:0]    tick_count_ff, tick_count_in;
   logic [NUM_SLOTS-1:0] slot_active_ff, slot_active_in;
   logic [TICK_W-1:0]    slot_start_ff   [NUM_SLOTS];
   logic [TICK_W-1:0]    slot_start_in   [NUM_SLOTS];
   logic [TICK_W-1:0]    slot_timeout_ff [NUM_SLOTS];
   logic [TICK_W-1:0]    slot_timeout_in [NUM_SLOTS];
   logic [MODE_W-1:0]    slot_mode_ff    [NUM_SLOTS];
   logic [MODE_W-1:0]    slot_mode_in    [NUM_SLOTS];

   logic [TICK_W-1:0]    due             [NUM_SLOTS];
   logic [NUM_SLOTS-1:0] reached;
   logic [NUM_SLOTS-1:0] hit;
   logic [MASK_SPAN-1:0] hit_span;
   logic [SLOT_W-1:0]    sel;
   logic                 in_range;

   // per-slot deadline compare, slot 0 is never tested
   always_comb begin
      for (int s = 0; s < NUM_SLOTS; s++) begin
         due[s]     = slot_start_ff[s] + slot_timeout_ff[s];
         reached[s] = (s != 0) && slot_active_ff[s] && (tick_count_ff >= due[s]);
      end
   end

   assign sel      = SLOT_W'(op.item.slot_index);
   assign in_range = 32'(op.item.slot_index) < 32'(NUM_SLOTS);

   // command decode and next state
   always_comb begin
      tick_count_in   = tick_count_ff;
      slot_active_in  = slot_active_ff;
      slot_start_in   = slot_start_ff;
      slot_timeout_in = slot_timeout_ff;
      slot_mode_in    = slot_mode_ff;
      hit             = '0;
      if (op.valid) begin
         unique case (op.item.cmd)
            CMD_TICK: begin
               tick_count_in = tick_count_ff + 1'b1;
            end
            CMD_START: begin
               if (in_range) begin
                  slot_timeout_in[sel] = op.item.timeout_ticks;
                  slot_start_in[sel]   = tick_count_ff;
                  slot_mode_in[sel]    = op.item.timer_mode;
                  slot_active_in[sel]  = 1'b1;
               end
            end
            CMD_STOP: begin
               if (in_range) begin
                  slot_active_in[sel] = 1'b0;
               end
            end
            CMD_POLL: begin
               hit = reached;
               for (int s = 0; s < NUM_SLOTS; s++) begin
                  if (reached[s]) begin
                     if (slot_mode_ff[s] == MODE_PERIODIC) begin
                        slot_start_in[s] = tick_count_ff;
                     end else if (slot_mode_ff[s] == MODE_ONE_SHOT) begin
                        slot_active_in[s] = 1'b0;
                     end
                  end
               end
            end
            default: begin
               tick_count_in = tick_count_ff;
            end
         endcase
      end
   end

   // slots above the mask width are dropped from the report
   assign hit_span            = MASK_SPAN'(hit);
   assign result.expired_mask = hit_span[MASK_W-1:0];
   assign result.tick_now     = tick_count_in;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         tick_count_ff  <= '0;
         slot_active_ff <= '0;
      end else begin
         tick_count_ff  <= tick_count_in;
         slot_active_ff <= slot_active_in;
      end
   end

   // slot payload, only read while the slot is active
   always_ff @(posedge clock) begin
      slot_start_ff   <= slot_start_in;
      slot_timeout_ff <= slot_timeout_in;
      slot_mode_ff    <= slot_mode_in;
   end

   // slot 0 is never reported
   assert property (@(posedge clock) disable iff (reset)
      op.valid |-> !result.expired_mask[0])
      else $error("slot 0 reported as expired");

   // only a poll reports anything
   assert property (@(posedge clock) disable iff (reset)
      (op.valid && (op.item.cmd != CMD_POLL)) |-> (result.expired_mask == '0))
      else $error("expiry reported outside a poll");

   // a tick advances the count by exactly one
   assert property (@(posedge clock) disable iff (reset)
      (op.valid && (op.item.cmd == CMD_TICK))
         |=> (tick_count_ff == $past(tick_count_ff) + 1'b1))
      else $error("tick count did not advance");

   // the count moves only on a tick
   assert property (@(posedge clock) disable iff (reset)
      !(op.valid && (op.item.cmd == CMD_TICK)) |=> $stable(tick_count_ff))
      else $error("tick count changed without a tick");

endmodule

### src/multi_slot_tick_timer.sv
// multi_slot_tick_timer
//
// 32-bit tick counter stepped by tick commands, plus a small table of timer slots.
// Request channel (req_valid/req_ready/req_payload) carries one command per
// transaction: tick, start slot, stop slot or poll. Every request produces
// exactly one response transaction on rsp_valid/rsp_ready/rsp_payload with
// the expired-slot mask (nonzero only for a poll) and the tick count after
// the command.
//
// Pipeline: an accepted request passes through two register stages, the
// request register and then the response register, which drives the
// response. Throughput is one request per cycle unless the receiver stalls;
// all slot compares run in parallel between the two registers.
//
// Reset clears the tick count and deactivates every slot; both channels
// come out of reset empty. When the receiver stalls, the response register
// holds its transaction and the request register takes one more request
// before req_ready drops, so nothing is lost or repeated.
module multi_slot_tick_timer import mstt_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_payload
);

   logic    req_valid_ff;
   req_type req_ff;
   logic    rsp_valid_ff;
   rsp_type rsp_ff;
   logic    advance;
   op_type  op;
   rsp_type result;

   // move the held request into the bank when the response slot is free
   assign advance   = req_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !req_valid_ff || advance;

   assign op.valid = advance;
   assign op.item  = req_ff;

   mstt_slot_bank u_bank (
      .clock  (clock),
      .reset  (reset),
      .op     (op),
      .result (result)
   );

   // request register
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_ready) begin
         req_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         req_ff <= req_payload;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule
